>>> rtl/core/fsc_pkg.sv
// fsc_pkg: shared constants and types for the farthest segment crossing core
// no dependencies
`default_nettype none
package fsc_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 6;
   localparam int CSR_ADDR_BITS  = 5;

   localparam logic [2:0] REG_PSX = 3'd0;
   localparam logic [2:0] REG_PSY = 3'd1;
   localparam logic [2:0] REG_PEX = 3'd2;
   localparam logic [2:0] REG_PEY = 3'd3;
   localparam logic [2:0] REG_RX  = 3'd4;
   localparam logic [2:0] REG_RY  = 3'd5;

   // classification of one candidate
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_START = 2'd1,  // crossing is probe start
      KIND_END   = 2'd2,  // crossing is probe end
      KIND_DIV   = 2'd3   // crossing needs the division
   } kind_type;
endpackage
`default_nettype wire

>>> rtl/core/fsc_front.sv
// fsc_front: classifies one candidate against the probe, registered over stages
// depends on fsc_pkg
`default_nettype none
module fsc_front import fsc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire signed [COORD_BITS-1:0] sx0, sy0, sx1, sy1,
   input  wire                         in_last,
   input  wire signed [COORD_BITS-1:0] psx, psy, pex, pey,
   output logic                        out_valid,
   input  wire                         out_ready,
   output kind_type                    out_kind,
   output logic                        out_last,
   output logic signed [2*COORD_BITS+3:0] out_tn,
   output logic signed [2*COORD_BITS+3:0] out_den
);
   localparam int D = COORD_BITS + 1;
   localparam int P = 2*COORD_BITS + 4;

   // full width signed product of two differences
   function automatic logic signed [2*D-1:0] smul(logic signed [D-1:0] a, logic signed [D-1:0] b);
      smul = a * b;
   endfunction

   // stage 1: differences
   logic s1_ff, s1_in;
   logic signed [D-1:0] dx_ff, dy_ff, ex_ff, ey_ff, wx_ff, wy_ff;
   logic signed [COORD_BITS-1:0] ax0_ff, ay0_ff, ax1_ff, ay1_ff, bx0_ff, by0_ff, bx1_ff, by1_ff;
   logic last1_ff;
   // stage 2: products
   logic s2_ff, s2_in;
   logic signed [P-1:0] den_ff, tn_ff, un_ff, dot_ff, len_ff, crs_ff;
   logic pdeg_ff, sdeg_ff, last2_ff;
   logic signed [COORD_BITS-1:0] a0_ff, a1_ff, b0_ff, b1_ff;
   logic stall;

   assign stall = out_valid && !out_ready;
   assign in_ready = !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0; s2_ff <= 1'b0; out_valid <= 1'b0;
      end else if (!stall) begin
         s1_ff <= s1_in; s2_ff <= s2_in; out_valid <= s2_ff;
      end
   end
   assign s1_in = in_valid;
   assign s2_in = s1_ff;

   always_ff @(posedge clock) begin
      if (!stall) begin
         dx_ff <= D'(pex) - D'(psx);
         dy_ff <= D'(pey) - D'(psy);
         ex_ff <= D'(sx1) - D'(sx0);
         ey_ff <= D'(sy1) - D'(sy0);
         wx_ff <= D'(sx0) - D'(psx);
         wy_ff <= D'(sy0) - D'(psy);
         ax0_ff <= psx; ay0_ff <= psy; ax1_ff <= pex; ay1_ff <= pey;
         bx0_ff <= sx0; by0_ff <= sy0; bx1_ff <= sx1; by1_ff <= sy1;
         last1_ff <= in_last;
      end
   end

   logic onx;
   always_comb begin
      logic [D-1:0] adx, ady;
      adx = dx_ff[D-1] ? -dx_ff : dx_ff;
      ady = dy_ff[D-1] ? -dy_ff : dy_ff;
      onx = adx >= ady;
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         den_ff <= P'(smul(dx_ff, ey_ff)) - P'(smul(dy_ff, ex_ff));
         tn_ff  <= P'(smul(wx_ff, ey_ff)) - P'(smul(wy_ff, ex_ff));
         un_ff  <= P'(smul(wx_ff, dy_ff)) - P'(smul(wy_ff, dx_ff));
         dot_ff <= -(P'(smul(wx_ff, ex_ff)) + P'(smul(wy_ff, ey_ff)));
         len_ff <= P'(smul(ex_ff, ex_ff)) + P'(smul(ey_ff, ey_ff));
         // ex*qy-ey*qx = -(...) zero test only
         crs_ff <= P'(smul(wx_ff, ey_ff)) - P'(smul(wy_ff, ex_ff));
         pdeg_ff <= (dx_ff == '0) && (dy_ff == '0);
         sdeg_ff <= (ex_ff == '0) && (ey_ff == '0);
         a0_ff <= onx ? ax0_ff : ay0_ff; a1_ff <= onx ? ax1_ff : ay1_ff;
         b0_ff <= onx ? bx0_ff : by0_ff; b1_ff <= onx ? bx1_ff : by1_ff;
         last2_ff <= last1_ff;
      end
   end

   // stage 3: classify
   kind_type kind;
   logic signed [P-1:0] tn_n, un_n, den_n;
   always_comb begin
      logic signed [COORD_BITS-1:0] lo, hi;
      lo = (a0_ff < a1_ff ? a0_ff : a1_ff) > (b0_ff < b1_ff ? b0_ff : b1_ff) ?
           (a0_ff < a1_ff ? a0_ff : a1_ff) : (b0_ff < b1_ff ? b0_ff : b1_ff);
      hi = (a0_ff > a1_ff ? a0_ff : a1_ff) < (b0_ff > b1_ff ? b0_ff : b1_ff) ?
           (a0_ff > a1_ff ? a0_ff : a1_ff) : (b0_ff > b1_ff ? b0_ff : b1_ff);
      tn_n  = den_ff[P-1] ? -tn_ff : tn_ff;
      un_n  = den_ff[P-1] ? -un_ff : un_ff;
      den_n = den_ff[P-1] ? -den_ff : den_ff;
      kind = KIND_NONE;
      if (sdeg_ff) kind = KIND_NONE;
      else if (pdeg_ff) begin
         if (crs_ff == '0 && !dot_ff[P-1] && dot_ff <= len_ff) kind = KIND_START;
      end else if (den_ff == '0) begin
         if (tn_ff == '0 && lo == hi) kind = (a0_ff == lo) ? KIND_START : KIND_END;
      end else if (!tn_n[P-1] && tn_n <= den_n && !un_n[P-1] && un_n <= den_n)
         kind = KIND_DIV;
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         out_kind <= kind;
         out_last <= last2_ff;
         out_tn   <= tn_n;
         out_den  <= den_n;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/fsc_fifo.sv
// fsc_fifo: short queue between classification and the back end
// depends on fsc_pkg
`default_nettype none
module fsc_fifo import fsc_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_ready,
   input  wire [WIDTH-1:0]  in_data,
   output logic             out_valid,
   input  wire              out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic wr, rd;
   assign in_ready = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign out_data = mem_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, wr} - {2'd0, rd};
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/fsc_back.sv
// fsc_back: point by restoring division, distance and running maximum
// depends on fsc_pkg
`default_nettype none
module fsc_back import fsc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  kind_type                    in_kind,
   input  wire                         in_last,
   input  wire signed [2*COORD_BITS+3:0] in_tn,
   input  wire signed [2*COORD_BITS+3:0] in_den,
   input  wire signed [COORD_BITS-1:0] psx, psy, pex, pey, rx, ry,
   output logic                        out_valid,
   input  wire                         out_ready,
   output logic                        out_found,
   output logic signed [COORD_BITS-1:0] out_x, out_y,
   output logic [2*COORD_BITS:0]       out_dist
);
   localparam int P  = 2*COORD_BITS + 4;
   localparam int N  = 3*COORD_BITS + 8;   // numerator width
   localparam int QB = COORD_BITS + 2;     // quotient magnitude fits
   localparam int CW = $clog2(QB + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_MUL = 6'b000010, ST_DIV = 6'b000100,
      ST_DST  = 6'b001000, ST_CMP = 6'b010000, ST_OUT = 6'b100000
   } state_type;
   state_type st_ff;

   // square of a difference, exact
   function automatic logic [2*COORD_BITS+1:0] sq(logic signed [COORD_BITS+1:0] v);
      logic signed [2*COORD_BITS+3:0] p;
      p = v * v;
      sq = p[2*COORD_BITS+1:0];
   endfunction

   logic last_ff, sel_ff;
   logic [P-1:0] den_ff;
   logic signed [P-1:0] tn_ff;
   logic signed [N-1:0] nx_ff, ny_ff;
   logic [N-1:0] rem_ff [2];
   logic [QB-1:0] q_ff [2];
   logic [CW-1:0] cnt_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [COORD_BITS+1:0] ddx_ff, ddy_ff;
   logic [2*COORD_BITS+1:0] dist_sq;
   logic have_ff;
   logic signed [COORD_BITS-1:0] kx_ff, ky_ff;
   logic [2*COORD_BITS+1:0] kd_ff;
   logic div_done_ff;
   logic signed [COORD_BITS-1:0] qx, qy;

   assign in_ready = st_ff == ST_IDLE;

   logic [N-1:0] ax, ay;
   assign ax = nx_ff[N-1] ? -nx_ff : nx_ff;
   assign ay = ny_ff[N-1] ? -ny_ff : ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; have_ff <= 1'b0; kd_ff <= '0; out_valid <= 1'b0;
         kx_ff <= '0; ky_ff <= '0;
      end else begin
         case (st_ff)
            ST_IDLE: if (in_valid) begin
               last_ff <= in_last; tn_ff <= in_tn; den_ff <= in_den;
               case (in_kind)
                  KIND_START: begin px_ff <= psx; py_ff <= psy; st_ff <= ST_DST; end
                  KIND_END:   begin px_ff <= pex; py_ff <= pey; st_ff <= ST_DST; end
                  KIND_DIV:   st_ff <= ST_MUL;
                  default:    st_ff <= ST_CMP;
               endcase
               sel_ff <= in_kind != KIND_NONE;
            end
            ST_MUL: begin
               nx_ff <= N'(psx) * N'(den_ff) + N'(tn_ff) * (N'(pex) - N'(psx));
               ny_ff <= N'(psy) * N'(den_ff) + N'(tn_ff) * (N'(pey) - N'(psy));
               cnt_ff <= CW'(QB); rem_ff[0] <= '0; rem_ff[1] <= '0;
               q_ff[0] <= '0; q_ff[1] <= '0;
               st_ff <= ST_DIV;
            end
            ST_DIV: begin
               // magnitude quotient, one bit a cycle from the top; the first step
               // starts from the numerator bits above the quotient range
               for (int k = 0; k < 2; k++) begin
                  logic [N-1:0] r, a, base;
                  logic [QB-1:0] al;
                  a = (k == 0) ? ax : ay;
                  al = a[QB-1:0];
                  base = (cnt_ff == CW'(QB)) ? (a >> QB) : rem_ff[k];
                  r = (base << 1) | N'(al[cnt_ff - 1'b1]);
                  if (r >= N'(den_ff)) begin
                     rem_ff[k] <= r - N'(den_ff);
                     q_ff[k] <= {q_ff[k][QB-2:0], 1'b1};
                  end else begin
                     rem_ff[k] <= r;
                     q_ff[k] <= {q_ff[k][QB-2:0], 1'b0};
                  end
               end
               if (cnt_ff == CW'(1)) st_ff <= ST_DST;
               cnt_ff <= cnt_ff - 1'b1;
            end
            ST_DST: begin
               if (div_done_ff) begin px_ff <= qx; py_ff <= qy; end
               st_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (sel_ff && dist_sq > kd_ff) begin
                  have_ff <= 1'b1; kx_ff <= px_ff; ky_ff <= py_ff; kd_ff <= dist_sq;
               end
               st_ff <= last_ff ? ST_OUT : ST_IDLE;
               sel_ff <= 1'b0;
               out_valid <= last_ff;
            end
            ST_OUT: if (out_ready) begin
               out_valid <= 1'b0; have_ff <= 1'b0; kd_ff <= '0;
               kx_ff <= '0; ky_ff <= '0; st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // quotient sign restore after the last division step
   always_ff @(posedge clock) begin
      if (reset) div_done_ff <= 1'b0;
      else div_done_ff <= (st_ff == ST_DIV) && (cnt_ff == CW'(1));
   end
   assign qx = COORD_BITS'(nx_ff[N-1] ? -$signed(q_ff[0]) : $signed(q_ff[0]));
   assign qy = COORD_BITS'(ny_ff[N-1] ? -$signed(q_ff[1]) : $signed(q_ff[1]));

   logic signed [COORD_BITS-1:0] ux, uy;
   assign ux = div_done_ff ? qx : px_ff;
   assign uy = div_done_ff ? qy : py_ff;
   always_ff @(posedge clock) begin
      if (st_ff == ST_DST) begin
         ddx_ff <= (COORD_BITS+2)'(ux) - (COORD_BITS+2)'(rx);
         ddy_ff <= (COORD_BITS+2)'(uy) - (COORD_BITS+2)'(ry);
      end
   end
   // distance is formed from the registered differences in compare state
   assign dist_sq = sq(ddx_ff) + sq(ddy_ff);

   assign out_found = have_ff;
   assign out_x = have_ff ? kx_ff : '0;
   assign out_y = have_ff ? ky_ff : '0;
   assign out_dist = have_ff ? kd_ff[2*COORD_BITS:0] : '0;

   a_outv: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> st_ff == ST_OUT) else $error("result outside output state");
   a_kd: assert property (@(posedge clock) disable iff (reset)
      !have_ff |-> kd_ff == '0) else $error("distance kept without a point");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> !out_valid) else $error("taking input while result pending");
endmodule
`default_nettype wire

>>> rtl/core/farthest_segment_crossing_core.sv
// farthest_segment_crossing_core: top level, csr block, front, queue and back end
// depends on fsc_pkg, fsc_front, fsc_fifo, fsc_back
// path: three front stages and one in the queue, then the back end states: IDLE, CMP with
// no crossing, IDLE, DST, CMP at an endpoint, IDLE, MUL, DIV, DST, CMP through the division
// the back end takes a segment only in IDLE, so it finishes one, bit-serial divider included,
// before it takes the next; after the last segment it waits in OUT for the result transfer
// reset: synchronous, clears configuration registers to 0, kept crossing and all handshakes
`default_nettype none
module farthest_segment_crossing_core import fsc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // seg_start_x, seg_start_y, seg_end_x, seg_end_y
   input  wire [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  wire         req_tlast,   // last_seg
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // best_x, best_y, best_dist_sq, zero fill
   output logic [((4*COORD_BITS+8)/8)*8-1:0] rsp_tdata,
   output logic        rsp_tuser,   // found
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire [31:0]  csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int P = 2*COORD_BITS + 4;
   localparam int QW = 2 + 2*P + 1;
   localparam int RSP_W = ((4*COORD_BITS+8)/8)*8;
   localparam int C = COORD_BITS;
   wire unused_frac = FRAC_BITS != 0; // binary point only, datapath unaffected

   // configuration registers
   logic signed [COORD_BITS-1:0] psx_ff, psy_ff, pex_ff, pey_ff, rx_ff, ry_ff;
   logic [2:0] idx;
   assign idx = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         psx_ff <= '0; psy_ff <= '0; pex_ff <= '0; pey_ff <= '0; rx_ff <= '0; ry_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (idx)
            REG_PSX: psx_ff <= csr_pwdata[COORD_BITS-1:0];
            REG_PSY: psy_ff <= csr_pwdata[COORD_BITS-1:0];
            REG_PEX: pex_ff <= csr_pwdata[COORD_BITS-1:0];
            REG_PEY: pey_ff <= csr_pwdata[COORD_BITS-1:0];
            REG_RX:  rx_ff  <= csr_pwdata[COORD_BITS-1:0];
            REG_RY:  ry_ff  <= csr_pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end
   // register read back, sign extended
   always_comb begin
      case (idx)
         REG_PSX: csr_prdata = 32'(psx_ff);
         REG_PSY: csr_prdata = 32'(psy_ff);
         REG_PEX: csr_prdata = 32'(pex_ff);
         REG_PEY: csr_prdata = 32'(pey_ff);
         REG_RX:  csr_prdata = 32'(rx_ff);
         REG_RY:  csr_prdata = 32'(ry_ff);
         default: csr_prdata = '0;
      endcase
   end

   // front end classification
   logic f_valid, f_ready, f_last;
   kind_type f_kind;
   logic signed [P-1:0] f_tn, f_den;
   fsc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .sx0(req_tdata[C-1:0]), .sy0(req_tdata[2*C-1:C]),
      .sx1(req_tdata[3*C-1:2*C]), .sy1(req_tdata[4*C-1:3*C]), .in_last(req_tlast),
      .psx(psx_ff), .psy(psy_ff), .pex(pex_ff), .pey(pey_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_kind(f_kind), .out_last(f_last),
      .out_tn(f_tn), .out_den(f_den));

   // queue decouples classification from the division
   logic q_valid, q_ready;
   logic [QW-1:0] q_data;
   fsc_fifo #(.WIDTH(QW)) u_fifo (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_data({f_kind, f_last, f_tn, f_den}),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data));

   logic b_found;
   logic signed [COORD_BITS-1:0] b_x, b_y;
   logic [2*COORD_BITS:0] b_dist;
   fsc_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready),
      .in_kind(kind_type'(q_data[QW-1:QW-2])), .in_last(q_data[2*P]),
      .in_tn(q_data[2*P-1:P]), .in_den(q_data[P-1:0]),
      .psx(psx_ff), .psy(psy_ff), .pex(pex_ff), .pey(pey_ff), .rx(rx_ff), .ry(ry_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_found(b_found),
      .out_x(b_x), .out_y(b_y), .out_dist(b_dist));

   assign rsp_tuser = b_found;
   assign rsp_tdata = RSP_W'({b_dist, b_y, b_x});
endmodule
`default_nettype wire
